[rtl/b64sc_pkg.sv]
package b64sc_pkg;

    // mode register codes
    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_DECODE = 1'b1;

    localparam logic [7:0] PAD_CHAR = 8'h3D;

    // job queue geometry
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // standard alphabet, first character in the top byte
    localparam logic [8*64-1:0] ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    // one group's worth of output beats
    typedef struct packed {
        logic [3:0][7:0] bytes;   // beat 0 in bytes[0]
        logic [2:0]      nres;    // beats in this job, 1 to 4
        logic            last;    // final beat closes the stream
        logic            empty;   // marker beat, no byte carried
        logic            bad;     // bad character seen in this stream
    } t_job;

    // queue status seen by the input handshake and the back end
    typedef struct packed {
        logic full;
        logic avail;
    } t_q_stat;

    // decoded character
    typedef struct packed {
        logic       ok;
        logic [5:0] val;
    } t_dec;

    function automatic logic [7:0] enc_char(input logic [5:0] idx);
        logic [8:0] pos;
        pos = {6'd63 - idx, 3'b000};
        return ALPHABET[pos +: 8];
    endfunction

    function automatic t_dec dec_char(input logic [7:0] c);
        t_dec       d;
        logic [7:0] t;
        d.ok  = 1'b1;
        t     = 8'd0;
        if (c inside {[8'h41:8'h5A]}) begin
            t = c - 8'd65;
        end else if (c inside {[8'h61:8'h7A]}) begin
            t = c - 8'd71;
        end else if (c inside {[8'h30:8'h39]}) begin
            t = c + 8'd4;
        end else if (c == 8'h2B) begin
            t = 8'd62;
        end else if (c == 8'h2F) begin
            t = 8'd63;
        end else begin
            d.ok = 1'b0;
        end
        d.val = t[5:0];
        return d;
    endfunction

endpackage

[rtl/b64sc_front.sv]
module b64sc_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic              i_cfg_wr_data,
    input  logic              i_fire,
    input  logic [7:0]        i_byte,
    input  logic              i_last,
    output logic              o_push,
    output b64sc_pkg::t_job   o_job
);
    import b64sc_pkg::*;

    logic        r_mode, n_mode;
    logic [23:0] r_bits, n_bits;
    logic [1:0]  r_count, n_count;
    logic [2:0]  r_pad, n_pad;
    logic        r_err, n_err;

    // group state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_ENCODE;
            r_bits  <= 24'd0;
            r_count <= 2'd0;
            r_pad   <= 3'd0;
            r_err   <= 1'b0;
        end else begin
            r_mode  <= n_mode;
            r_bits  <= n_bits;
            r_count <= n_count;
            r_pad   <= n_pad;
            r_err   <= n_err;
        end
    end

    logic [2:0]  k;
    logic [23:0] nbits;
    logic [23:0] g;
    logic        flush;
    t_dec        d;
    logic        is_pad;
    logic [5:0]  v;
    logic [2:0]  pad_nx;
    logic        err_nx;
    logic [2:0]  nonpad;
    logic [2:0]  nb;

    // classify the beat and build the job
    always_comb begin
        n_mode  = r_mode;
        n_bits  = r_bits;
        n_count = r_count;
        n_pad   = r_pad;
        n_err   = r_err;
        o_push  = 1'b0;
        o_job   = '0;
        k       = {1'b0, r_count} + 3'd1;
        d       = dec_char(i_byte);
        is_pad  = (i_byte == PAD_CHAR);
        v       = (is_pad || !d.ok) ? 6'd0 : d.val;
        pad_nx  = r_pad + {2'b00, is_pad};
        err_nx  = r_err | (!is_pad && !d.ok);
        nbits   = 24'd0;
        g       = 24'd0;
        flush   = 1'b0;
        nonpad  = 3'd0;
        nb      = 3'd0;

        if (r_mode == MODE_ENCODE) begin
            if (k > 3'd3) k = 3'd3;
            nbits = {r_bits[15:0], i_byte};
            flush = (k == 3'd3) || i_last;
            case (k)
                3'd1:    g = {nbits[7:0], 16'd0};
                3'd2:    g = {nbits[15:0], 8'd0};
                default: g = nbits;
            endcase
            o_job.bytes[0] = enc_char(g[23:18]);
            o_job.bytes[1] = enc_char(g[17:12]);
            o_job.bytes[2] = (k == 3'd1) ? PAD_CHAR : enc_char(g[11:6]);
            o_job.bytes[3] = (k <= 3'd2) ? PAD_CHAR : enc_char(g[5:0]);
            o_job.nres     = 3'd4;
            o_job.last     = i_last;
            o_job.bad      = r_err;
            if (i_fire) begin
                o_push = flush;
                if (flush) begin
                    n_bits  = 24'd0;
                    n_count = 2'd0;
                end else begin
                    n_bits  = nbits;
                    n_count = k[1:0];
                end
            end
        end else begin
            nbits = {r_bits[17:0], v};
            flush = (k == 3'd4) || i_last;
            case (k)
                3'd1:    g = {nbits[5:0], 18'd0};
                3'd2:    g = {nbits[11:0], 12'd0};
                3'd3:    g = {nbits[17:0], 6'd0};
                default: g = nbits;
            endcase
            nonpad = k - pad_nx;
            nb     = (nonpad > 3'd1) ? nonpad - 3'd1 : 3'd0;
            o_job.bad = err_nx;
            o_job.last = i_last;
            if (nb != 3'd0) begin
                o_job.bytes[0] = g[23:16];
                o_job.bytes[1] = g[15:8];
                o_job.bytes[2] = g[7:0];
                o_job.nres     = nb;
            end else begin
                o_job.nres  = 3'd1;
                o_job.empty = 1'b1;
            end
            if (i_fire) begin
                o_push = flush && ((nb != 3'd0) || i_last);
                if (flush) begin
                    n_bits  = 24'd0;
                    n_count = 2'd0;
                    n_pad   = 3'd0;
                    n_err   = i_last ? 1'b0 : err_nx;
                end else begin
                    n_bits  = nbits;
                    n_count = k[1:0];
                    n_pad   = pad_nx;
                    n_err   = err_nx;
                end
            end
        end

        // a mode write starts a new stream
        if (i_cfg_wr_en) begin
            n_mode  = i_cfg_wr_data;
            n_bits  = 24'd0;
            n_count = 2'd0;
            n_pad   = 3'd0;
            n_err   = 1'b0;
        end
    end

endmodule

[rtl/b64sc_queue.sv]
module b64sc_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  b64sc_pkg::t_job   i_job,
    input  logic              i_pop,
    output b64sc_pkg::t_job   o_head,
    output b64sc_pkg::t_q_stat o_stat
);
    import b64sc_pkg::*;

    t_job                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_AW:0]   r_used;

    logic do_push;
    logic do_pop;

    assign o_stat.full  = (r_used == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_stat.avail = (r_used != '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && o_stat.avail;
    assign o_head       = r_mem[r_rd_ptr];

    // job storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_used   <= '0;
        end else begin
            if (do_push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (do_pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            case ({do_push, do_pop})
                2'b10:   r_used <= r_used + 1'b1;
                2'b01:   r_used <= r_used - 1'b1;
                default: r_used <= r_used;
            endcase
        end
    end

endmodule

[rtl/b64sc_back.sv]
module b64sc_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  b64sc_pkg::t_job    i_head,
    input  b64sc_pkg::t_q_stat i_stat,
    output logic               o_pop,
    output logic               o_m_tvalid,
    input  logic               i_m_tready,
    output logic [7:0]         o_m_tdata,
    output logic               o_m_tlast,
    output logic [1:0]         o_m_tuser
);
    import b64sc_pkg::*;

    logic       r_busy;
    t_job       r_job;
    logic [1:0] r_idx;

    logic beat_done;
    logic final_beat;
    logic load;

    assign beat_done  = r_busy && i_m_tready;
    assign final_beat = ({1'b0, r_idx} == (r_job.nres - 3'd1));
    assign load       = !r_busy || (beat_done && final_beat);
    assign o_pop      = load && i_stat.avail;

    // working job and beat index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= 2'd0;
        end else if (o_pop) begin
            r_busy <= 1'b1;
            r_idx  <= 2'd0;
        end else if (load) begin
            r_busy <= 1'b0;
        end else if (beat_done) begin
            r_idx  <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_head;
        end
    end

    // output beat
    assign o_m_tvalid = r_busy;
    assign o_m_tdata  = r_job.bytes[r_idx];
    assign o_m_tlast  = r_job.last && final_beat;
    assign o_m_tuser  = {r_job.bad, r_job.empty};

endmodule

[rtl/base64_stream_codec.sv]
// channel   dir  handshake              payload
// s         in   i_s_tvalid/o_s_tready  tdata: in_byte; tlast: in_last
// m         out  o_m_tvalid/i_m_tready  tdata: out_byte; tlast: out_last;
//                                       tuser: out_empty, bad_char
// cfg       in   i_cfg_wr_en            i_cfg_wr_data: mode
//
// one input beat per cycle is taken while the four-entry job queue has room
// the back end sends one output beat per cycle while it holds a job and the
// sink is ready, so encoding sustains four output beats per three input
// beats and the output port sets the pace
// reset is synchronous, active low; either side may stall without loss
module base64_stream_codec (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic       i_cfg_wr_data,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,    // [7:0] in_byte
    input  logic       i_s_tlast,
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,    // [7:0] out_byte
    output logic       o_m_tlast,
    output logic [1:0] o_m_tuser     // [0] out_empty, [1] bad_char
);
    import b64sc_pkg::*;

    t_job    w_push_job;
    t_job    w_head;
    t_q_stat w_stat;
    logic    w_push;
    logic    w_pop;
    logic    w_fire;

    assign o_s_tready = !w_stat.full;
    assign w_fire     = i_s_tvalid && o_s_tready;

    // input side: group assembly and job build
    b64sc_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_fire        (w_fire),
        .i_byte        (i_s_tdata),
        .i_last        (i_s_tlast),
        .o_push        (w_push),
        .o_job         (w_push_job)
    );

    // job queue between the two sides
    b64sc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_stat  (w_stat)
    );

    // output side: job to beats
    b64sc_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (w_head),
        .i_stat     (w_stat),
        .o_pop      (w_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

endmodule
